>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants of the modular exponentiation core
// Holds the word width of the channels and the control and status bundles
// that pass between the sequencer and the modular reduction unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Width of every field that crosses the channels.
  localparam int unsigned WORD_BITS = 32;

  // Request from the sequencer to the reduction unit.
  typedef struct packed {
    logic start;
  } red_ctl_t;

  // Status from the reduction unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } red_sts_t;

endpackage

`default_nettype wire

>>> rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if: channel interfaces of the modular exponentiation core
// One interface carries the operand word, the other the result word, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::WORD_BITS-1:0] base;
  logic [mexp_pkg::WORD_BITS-1:0] exponent;
  logic [mexp_pkg::WORD_BITS-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus,
                  input ready);
  modport sink   (input valid, input base, input exponent, input modulus,
                  output ready);
endinterface

interface mexp_out_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::WORD_BITS-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

>>> rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core: left-to-right square-and-multiply modexp
// Computes base ** exponent mod modulus with one multiplier and one shared
// bit-serial reduction unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel     Dir   Word                         Handshake
//   operands    in    base, exponent, modulus      valid / ready
//   result      out   power_mod                    valid / ready
//
// One word is taken at a time. A multiply step registers the product, starts
// a reduction, runs one reduction step per operand bit and ends on done; a
// squaring first picks the exponent bit, and the base reduction needs no
// product step. The count of reductions is one for the base plus one per
// squaring and one per set exponent bit below the top one. A 32-bit exponent
// of all ones is the slowest word.
// Reset is synchronous and clears the sequencer and the result valid flag.
// The result word sits in an output register: when the sink stalls, the
// finished answer waits there and the sequencer holds until it can be moved.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mexp_in_if.sink     operands,
  mexp_out_if.source  result
);

  localparam int unsigned N    = OPERAND_BITS;
  localparam int unsigned P    = 2 * N;
  localparam int unsigned LW   = (N > 2) ? $clog2(N) : 1;
  localparam logic [LW-1:0] LEFT_INIT = LW'(N - 1);
  localparam logic [LW-1:0] LEFT_ONE  = LW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an operand word
  localparam logic [2:0] S_RSTART = 3'd1;  // launch a reduction of prod
  localparam logic [2:0] S_RWAIT  = 3'd2;  // reduction in flight
  localparam logic [2:0] S_SCAN   = 3'd3;  // hunting the top exponent bit
  localparam logic [2:0] S_LOOP   = 3'd4;  // pick the next exponent bit
  localparam logic [2:0] S_MUL    = 3'd5;  // register one product
  localparam logic [2:0] S_HOLD   = 3'd6;  // hand the answer to the output

  // What the reduction in flight is for.
  localparam logic [1:0] PH_BASE = 2'd0;   // base mod modulus
  localparam logic [1:0] PH_SQR  = 2'd1;   // squaring step
  localparam logic [1:0] PH_MULB = 2'd2;   // multiply-by-base step

  logic [2:0]   state;
  logic [1:0]   phase;
  logic [N-1:0] base_r;
  logic [N-1:0] exp_r;
  logic [N-1:0] mod_r;
  logic [N-1:0] acc;
  logic [N-1:0] res;
  logic [LW-1:0] left;
  logic         sel_base;
  logic [P-1:0] prod;

  logic                         out_valid;
  logic [mexp_pkg::WORD_BITS-1:0] out_word;

  mexp_pkg::red_ctl_t red_ctl;
  mexp_pkg::red_sts_t red_sts;
  logic [N-1:0]       red_rem;

  logic               accept;
  logic               out_free;
  logic [N-1:0]       mul_b;
  logic [mexp_pkg::WORD_BITS-1:0] res_wide;

  assign accept   = operands.valid && operands.ready;
  assign out_free = !out_valid || result.ready;
  assign mul_b    = sel_base ? base_r : acc;
  assign red_ctl.start = (state == S_RSTART);

  always_comb begin
    res_wide        = '0;
    res_wide[N-1:0] = res;
  end

  // The single reduction unit serves the base reduction and every step.
  mexp_modred #(
    .OPERAND_BITS(N)
  ) u_modred (
    .clk      (clk),
    .rst      (rst),
    .ctl      (red_ctl),
    .dividend (prod),
    .modulus  (mod_r),
    .sts      (red_sts),
    .remainder(red_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_BASE;
      out_valid <= 1'b0;
    end else begin
      // The output register is loaded from the hold state once it is free,
      // and otherwise empties when the sink takes its word.
      if ((state == S_HOLD) && out_free) begin
        out_word  <= res_wide;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            base_r <= operands.base[N-1:0];
            exp_r  <= operands.exponent[N-1:0];
            mod_r  <= operands.modulus[N-1:0];
            left   <= LEFT_INIT;
            prod   <= P'(operands.base[N-1:0]);
            phase  <= PH_BASE;
            if (operands.modulus[N-1:0] == '0) begin
              // A zero modulus yields zero without any reduction.
              res   <= '0;
              state <= S_HOLD;
            end else begin
              state <= S_RSTART;
            end
          end
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (red_sts.done) begin
            unique case (phase)
              PH_BASE: begin
                base_r <= red_rem;
                if (exp_r == '0) begin
                  // Zero exponent: 1 mod modulus.
                  res   <= (mod_r == N'(1)) ? '0 : N'(1);
                  state <= S_HOLD;
                end else begin
                  state <= S_SCAN;
                end
              end
              PH_SQR: begin
                acc <= red_rem;
                if (exp_r[N-1]) begin
                  phase    <= PH_MULB;
                  sel_base <= 1'b1;
                  state    <= S_MUL;
                end else begin
                  exp_r <= {exp_r[N-2:0], 1'b0};
                  left  <= left - LEFT_ONE;
                  state <= S_LOOP;
                end
              end
              default: begin
                acc   <= red_rem;
                exp_r <= {exp_r[N-2:0], 1'b0};
                left  <= left - LEFT_ONE;
                state <= S_LOOP;
              end
            endcase
          end
        end
        S_SCAN: begin
          // The top set bit itself only seeds the accumulator with the base.
          exp_r <= {exp_r[N-2:0], 1'b0};
          if (exp_r[N-1]) begin
            acc   <= base_r;
            state <= S_LOOP;
          end else begin
            left <= left - LEFT_ONE;
          end
        end
        S_LOOP: begin
          if (left == '0) begin
            res   <= acc;
            state <= S_HOLD;
          end else begin
            phase    <= PH_SQR;
            sel_base <= 1'b0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= P'(acc) * P'(mul_b);
          state <= S_RSTART;
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign operands.ready   = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.power_mod = out_word;

  // The reduction unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    red_sts.done |-> (state == S_RWAIT))
    else $error("reduction finished outside its wait state");

  // The accumulator is always a reduced residue when a bit is picked.
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> (acc < mod_r))
    else $error("accumulator not below modulus");

  // A reduction is never launched while the unit is still busy.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    red_ctl.start |-> !red_sts.busy)
    else $error("reduction started while unit busy");

  // A zero modulus goes straight to the output with a zero answer.
  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    (accept && (operands.modulus[N-1:0] == '0)) |=>
      ((state == S_HOLD) && (res == '0)))
    else $error("zero modulus not short-cut to zero");

endmodule

`default_nettype wire

>>> rtl/mexp_modred.sv
// ----------------------------------------------------------------------------
// mexp_modred: bit-serial modular reduction unit
// Reduces a double-width dividend whose upper half is already below the
// modulus, one restoring compare-and-subtract step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mexp_modred #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mexp_pkg::red_ctl_t          ctl,
  input  wire logic [2*OPERAND_BITS-1:0]   dividend,
  input  wire logic [OPERAND_BITS-1:0]     modulus,
  output mexp_pkg::red_sts_t               sts,
  output logic [OPERAND_BITS-1:0]          remainder
);

  localparam int unsigned N      = OPERAND_BITS;
  localparam int unsigned CNT_W  = $clog2(N + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(N);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  logic [N-1:0]     rem;
  logic [N-1:0]     low;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [N:0]       trial;
  logic [N:0]       diff;
  logic             fits;

  // The running remainder stays below the modulus, so the trial value is
  // below twice the modulus and one subtraction suffices.
  always_comb begin
    trial = {rem, low[N-1]};
    diff  = trial - {1'b0, modulus};
    fits  = trial >= {1'b0, modulus};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
        rem  <= dividend[2*N-1:N];
        low  <= dividend[N-1:0];
      end else if (busy) begin
        rem <= fits ? diff[N-1:0] : trial[N-1:0];
        low <= {low[N-2:0], 1'b0};
        cnt <= cnt - ONE;
        if (cnt == ONE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the modular exponentiation core
// Drives operand words through the input channel and compares every result
// word against its table answer or a square-and-multiply predictor. A short
// corner table comes first, then a few hundred random words, with bursty
// input, a stalling result sink and one long sink hold-off that backs up the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned OPERAND_BITS  = 32;
  localparam int          RANDOM_WORDS  = 248;
  // A full 32-bit exponent of all ones is the slowest word.
  localparam int          DRAIN_CYCLES  = 2300;
  localparam int          HOLD_CYCLES   = 6000;
  localparam int          HOLD_AFTER    = 30;

  typedef logic [mexp_pkg::WORD_BITS-1:0] word_t;

  // One row of the corner-case table. Where has_answer is set the answer is
  // taken as written; otherwise the predictor supplies it.
  typedef struct packed {
    word_t base;
    word_t exponent;
    word_t modulus;
    logic  has_answer;
    word_t answer;
  } corner_row_t;

  // What the core owes us for one accepted operand word.
  typedef struct packed {
    word_t base;
    word_t exponent;
    word_t modulus;
    word_t power_mod;
  } owed_power_t;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  logic clk;
  logic rst;

  mexp_in_if  op_if ();
  mexp_out_if res_if ();

  modular_exponentiation_core #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .operands(op_if),
    .result  (res_if)
  );

  owed_power_t pending_powers [$];
  int          words_sent;
  int          results_checked;
  int          mismatch_count;
  int          corner_count;

  corner_row_t corner_rows [22] = '{
    // Zero exponent, with unit and wide moduli.
    '{32'd0,          32'd0,          32'd1,          1'b1, 32'd0},
    '{32'd5,          32'd0,          32'd7,          1'b1, 32'd1},
    '{32'd0,          32'd0,          32'd7,          1'b1, 32'd1},
    '{32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
    // Unit modulus always gives zero.
    '{32'd123,        32'd456,        32'd1,          1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,          1'b1, 32'd0},
    // Zero base, small powers, and bases at or above the modulus.
    '{32'd0,          32'd5,          32'd13,         1'b1, 32'd0},
    '{32'd2,          32'd10,         32'd1000,       1'b1, 32'd24},
    '{32'd3,          32'd1,          32'd7,          1'b1, 32'd3},
    '{32'd10,         32'd1,          32'd7,          1'b1, 32'd3},
    '{32'd97,         32'd3,          32'd97,         1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFF,  1'b1, 32'd0},
    '{32'hFFFF_FFFE,  32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd2,          32'd31,         32'hFFFF_FFFF,  1'b1, 32'h8000_0000},
    '{32'd2,          32'd32,         32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd1,          32'hFFFF_FFFF,  32'd2,          1'b1, 32'd1},
    // Zero modulus is outside the legal range and must come back as zero.
    '{32'd12345,      32'd6789,       32'd0,          1'b1, 32'd0},
    '{32'd0,          32'd0,          32'd0,          1'b1, 32'd0},
    // Widest operands, left to the predictor.
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFB,  1'b0, 32'd0},
    '{32'd3,          32'h8000_0000,  32'hFFFF_FFFB,  1'b0, 32'd0},
    '{32'hDEAD_BEEF,  32'h1234_5678,  32'h8000_0000,  1'b0, 32'd0}
  };

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // base ** exponent mod modulus, scanning exponent bits from the top set one.
  function automatic word_t power_mod_of(input word_t base_in, input word_t exp_in,
                                         input word_t mod_in);
    logic [63:0] opmask;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    int          top;
    opmask = (64'd1 << OPERAND_BITS) - 64'd1;
    b = {32'd0, base_in} & opmask;
    e = {32'd0, exp_in} & opmask;
    m = {32'd0, mod_in} & opmask;
    if (m == 64'd0) return '0;
    b = b % m;
    if (e == 64'd0) begin
      acc = 64'd1 % m;
      return acc[mexp_pkg::WORD_BITS-1:0];
    end
    top = OPERAND_BITS - 1;
    while (top > 0 && e[top] == 1'b0) top--;
    acc = b;
    for (int k = top - 1; k >= 0; k--) begin
      acc = (acc * acc) % m;
      if (e[k]) acc = (acc * b) % m;
    end
    return acc[mexp_pkg::WORD_BITS-1:0];
  endfunction

  // Present one operand word from a falling edge, hold it until the core takes
  // it, record what is owed, and return at the next falling edge with valid
  // still high so a back-to-back word needs no second assignment.
  task automatic offer_operands(input word_t b, input word_t e, input word_t m,
                                input logic has_answer, input word_t answer);
    owed_power_t owed;
    op_if.valid    <= 1'b1;
    op_if.base     <= b;
    op_if.exponent <= e;
    op_if.modulus  <= m;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    owed.base      = b;
    owed.exponent  = e;
    owed.modulus   = m;
    owed.power_mod = has_answer ? answer : power_mod_of(b, e, m);
    pending_powers.push_back(owed);
    words_sent++;
    @(negedge clk);
  endtask

  // Bursts of random length separated by random gaps; some gaps are zero so
  // long runs go by with no idling at all.
  task automatic pace_sender(inout int burst_left);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        op_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Random operand word. Most words are well formed with a modulus of random
  // width and its top bit set; the rest are raw 32-bit noise, tiny moduli, or power-of-two exponents.
  task automatic make_random_word(output word_t b, output word_t e, output word_t m);
    int wm;
    int we;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        wm = $urandom_range(2, 32);
        we = $urandom_range(1, 32);
        m  = ($urandom | (32'd1 << (wm - 1))) & (32'hFFFF_FFFF >> (32 - wm));
        e  = $urandom >> (32 - we);
        b  = $urandom;
      end
      6, 7: begin
        b = $urandom;
        e = $urandom;
        m = $urandom;
      end
      8: begin
        // Tiny moduli make collisions with zero and one common.
        b = $urandom;
        e = $urandom >> $urandom_range(0, 31);
        m = $urandom_range(1, 17);
      end
      default: begin
        // Powers of two in the exponent and a base at or just above the modulus.
        m = $urandom | 32'h8000_0000;
        b = m + $urandom_range(0, 3);
        e = 32'd1 << $urandom_range(0, 31);
      end
    endcase
    if (m == '0) m = 32'd1;
  endtask

  // Result sink: picks a new stall pattern for each random-length segment, and once,
  // after the first few dozen words, holds ready low for a long stretch so
  // the finished answer parks in the output register and the core backs up.
  initial begin : result_sink
    int         seg_left;
    int         hold_left;
    int         phase_cnt;
    bit         hold_done;
    sink_mode_e mode;
    res_if.ready = 1'b0;
    seg_left  = 0;
    hold_left = 0;
    phase_cnt = 0;
    hold_done = 1'b0;
    mode      = SINK_OPEN;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (seg_left <= 0) begin
          mode     = sink_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(50, 400);
        end
        seg_left--;
        phase_cnt++;
        case (mode)
          SINK_OPEN:     res_if.ready <= 1'b1;
          SINK_COIN:     res_if.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE:   res_if.ready <= ($urandom_range(0, 7) == 0);
          SINK_PERIODIC: res_if.ready <= (phase_cnt % 3 == 0);
          default:       res_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker: every word that leaves the core must match the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    owed_power_t owed;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result power_mod=%h with nothing outstanding",
                 $time, res_if.power_mod);
      end else begin
        owed = pending_powers.pop_front();
        results_checked++;
        if (res_if.power_mod !== owed.power_mod) begin
          mismatch_count++;
          $display("%0t: power_mod mismatch base=%h exponent=%h modulus=%h expected=%h actual=%h",
                   $time, owed.base, owed.exponent, owed.modulus, owed.power_mod,
                   res_if.power_mod);
        end
      end
    end
  end

  // Main sequence: reset, corner table, random words, drain, verdict.
  initial begin : stimulus
    int    burst_left;
    word_t b;
    word_t e;
    word_t m;
    rst             = 1'b1;
    op_if.valid     = 1'b0;
    op_if.base      = '0;
    op_if.exponent  = '0;
    op_if.modulus   = '0;
    words_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    corner_count    = 0;
    burst_left      = $urandom_range(1, 8);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_rows[i]) begin
      offer_operands(corner_rows[i].base, corner_rows[i].exponent, corner_rows[i].modulus,
                     corner_rows[i].has_answer, corner_rows[i].answer);
      corner_count++;
      pace_sender(burst_left);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      make_random_word(b, e, m);
      offer_operands(b, e, m, 1'b0, '0);
      pace_sender(burst_left);
    end
    op_if.valid <= 1'b0;

    while (pending_powers.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d corner words and %0d random words, %0d results checked.",
             corner_count, words_sent - corner_count, results_checked);
    $display("Random part mixed shaped, noise, tiny-modulus and power-of-two exponents.");
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #30_000_000;
    $display("Timed out with %0d results still outstanding.", pending_powers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_modred.sv
rtl/modular_exponentiation_core.sv
bench/tb.sv
